// ----- hw/rtl/segment_display_marquee_macros.svh -----
// Assertion macros shared by the marquee RTL files.
`ifndef SEGMENT_DISPLAY_MARQUEE_MACROS_SVH
`define SEGMENT_DISPLAY_MARQUEE_MACROS_SVH
`ifndef ASSERT_OFF
`define SDM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`define SDM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define SDM_ASSERT_IMP(lbl, ante, cons, msg)
`define SDM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/sdm_pkg.sv -----
// Types, codes and constants shared by the marquee modules.
package sdm_pkg;

   localparam int LINE_LENGTH = 64;
   localparam int MAX_DIGITS  = 8;
   localparam int STORE_DEPTH = LINE_LENGTH + 1;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int POS_W       = $clog2(LINE_LENGTH + MAX_DIGITS + 1);
   localparam int SCAN_W      = $clog2(MAX_DIGITS + 3);
   localparam int DIGIT_W     = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [1:0] FUNC_BYTE = 2'd0;
   localparam logic [1:0] FUNC_TICK = 2'd1;
   localparam logic [1:0] FUNC_STOP = 2'd2;

   localparam logic [1:0] CSR_CHAR_DELAY    = 2'd0;
   localparam logic [1:0] CSR_END_DELAY     = 2'd1;
   localparam logic [1:0] CSR_DIGITS_IN_USE = 2'd2;

   localparam logic [15:0] CHAR_DELAY_RST = 16'd1000;
   localparam logic [15:0] END_DELAY_RST  = 16'd0;
   localparam logic [3:0]  DIGITS_RST     = 4'd4;

   typedef enum logic [1:0] {
      OP_BYTE,
      OP_NEWLINE,
      OP_TICK,
      OP_STOP
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TERM,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] char_val;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit_index;
      logic [7:0]         char_out;
      logic               last_digit;
      logic               still_running;
   } rsp_type;

endpackage

// ----- hw/rtl/segment_display_marquee.sv -----
// A byte word is written to the store and then followed by its terminator (ST_TERM); a newline
// or stop word is written when it is taken. A tick that ends the delay starts an update: the
// back end walks the store one read a cycle, n + 2 reads (n = digits in use), decides, then
// sends one digit word per cycle while the output is free, until the last digit word is sent.
// Throughput: one word a cycle into the queue while it has room; an update holds the back end.
// Reset is synchronous; it empties the line store at once through its valid bits.
module segment_display_marquee (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sdm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sdm_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   logic             fr_valid;
   logic             fr_ready;
   sdm_pkg::cmd_type fr_cmd;
   logic             q_valid;
   logic             q_pop;
   sdm_pkg::cmd_type q_cmd;

   sdm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (fr_valid),
      .cmd_ready (fr_ready),
      .cmd_data  (fr_cmd)
   );

   sdm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_cmd),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_cmd)
   );

   sdm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_data  (q_cmd),
      .cmd_pop   (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hw/rtl/sdm_queue.sv -----
// Small command queue between the marquee front end and back end.
module sdm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  sdm_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop,
   output sdm_pkg::cmd_type pop_data
);

   sdm_pkg::cmd_type entry_ff [sdm_pkg::QUEUE_DEPTH];
   logic [sdm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sdm_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sdm_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign push_ready = (count_ff != sdm_pkg::QCNT_W'(sdm_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sdm_pkg::QPTR_W'(sdm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + sdm_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sdm_pkg::QPTR_W'(sdm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + sdm_pkg::QPTR_W'(1);
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + sdm_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - sdm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`include "segment_display_marquee_macros.svh"

   `SDM_ASSERT_IMP(a_empty_ptrs, count_ff == '0, rd_ptr_ff == wr_ptr_ff, "queue empty but pointers differ")

endmodule

// ----- hw/rtl/sdm_front.sv -----
// Front end: takes request words and turns them into back-end commands.
module sdm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sdm_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output sdm_pkg::cmd_type cmd_data
);

   logic             fr_valid_ff, fr_valid_in;
   sdm_pkg::cmd_type fr_cmd_ff, fr_cmd_in;
   logic             keep;
   sdm_pkg::cmd_type decoded;

   assign req_ready = !fr_valid_ff || cmd_ready;
   assign cmd_valid = fr_valid_ff;
   assign cmd_data  = fr_cmd_ff;

   // Carriage returns and the unused function code produce no command.
   always_comb begin
      keep             = 1'b1;
      decoded.op       = sdm_pkg::OP_BYTE;
      decoded.char_val = req_data.char_in;
      case (req_data.func)
         sdm_pkg::FUNC_BYTE: begin
            if (req_data.char_in == sdm_pkg::CHAR_NL) begin
               decoded.op = sdm_pkg::OP_NEWLINE;
            end else if (req_data.char_in == sdm_pkg::CHAR_CR) begin
               keep = 1'b0;
            end
         end
         sdm_pkg::FUNC_TICK: decoded.op = sdm_pkg::OP_TICK;
         sdm_pkg::FUNC_STOP: decoded.op = sdm_pkg::OP_STOP;
         default: keep = 1'b0;
      endcase
   end

   always_comb begin
      fr_valid_in = fr_valid_ff && !cmd_ready;
      fr_cmd_in   = fr_cmd_ff;
      if (req_valid && req_ready) begin
         fr_valid_in = keep;
         fr_cmd_in   = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fr_cmd_ff <= fr_cmd_in;
   end

endmodule

// ----- hw/rtl/sdm_back.sv -----
// Back end: line store, scroll state, update scan and per-digit output.
module sdm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  sdm_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sdm_pkg::rsp_type rsp_data
);

   localparam int PW = sdm_pkg::POS_W;
   localparam int SW = sdm_pkg::SCAN_W;
   localparam int DW = sdm_pkg::DIGIT_W;

   // Configuration registers.
   logic [15:0] char_delay_ff, char_delay_in;
   logic [15:0] end_delay_ff, end_delay_in;
   logic [3:0]  digits_ff, digits_in;

   sdm_pkg::back_state_type state_ff, state_in;

   logic [PW-1:0] wr_idx_ff, wr_idx_in;
   logic [PW-1:0] rd_idx_ff, rd_idx_in;
   logic          running_ff, running_in;
   logic          blanking_ff, blanking_in;
   logic [15:0]   countdown_ff, countdown_in;

   logic [SW-1:0] issue_cnt_ff, issue_cnt_in;
   logic          rd_valid_ff;
   logic [SW-1:0] rd_tag_ff;
   logic [7:0]    mem_q_ff;
   logic          mem_hit_ff;
   logic [7:0]    text0_ff, text0_in;
   logic [7:0]    prev_ff, prev_in;
   logic [7:0]    first_ff, first_in;
   logic          blink_ok_ff, blink_ok_in;
   logic          zero_seen_ff, zero_seen_in;
   logic          blink_ff, blink_in;
   logic [DW-1:0] emit_cnt_ff, emit_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sdm_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [7:0]    window_ff [sdm_pkg::MAX_DIGITS];

   // Line store with one valid bit per entry; an entry never written reads as zero.
   logic [7:0]                     store_mem [sdm_pkg::STORE_DEPTH];
   logic [sdm_pkg::STORE_DEPTH-1:0] vld_ff;

   logic                    mem_we;
   logic [PW-1:0]           mem_waddr;
   logic [7:0]              mem_wdata;
   logic                    rd_en;
   logic [PW-1:0]           rd_addr;
   logic                    rd_oob;
   logic [sdm_pkg::STORE_AW-1:0] rd_sel;
   logic [7:0]              rd_char;

   logic          win_we;
   logic [DW-1:0] win_idx;
   logic [7:0]    win_data;

   logic [3:0]    digit_cnt;
   logic [SW-1:0] scan_last;
   logic [PW-1:0] scan_addr;
   logic          scan_done;
   logic [15:0]   cd_dec;
   logic          rsp_free;
   logic          emit_last;
   logic          byte_fits;

   logic          first_zero;
   logic [15:0]   base_delay;
   logic [15:0]   quarter;
   logic          blink_now;
   logic          stop_now;
   logic [15:0]   delay_new;

   assign digit_cnt = (digits_ff == 4'd0) ? 4'd1 :
                      (digits_ff > 4'(sdm_pkg::MAX_DIGITS)) ? 4'(sdm_pkg::MAX_DIGITS) :
                      digits_ff;
   assign scan_last = SW'(digit_cnt) + SW'(1);
   assign scan_addr = (issue_cnt_ff == '0) ? '0 :
                      rd_idx_ff + PW'(issue_cnt_ff) - PW'(2);
   assign scan_done = rd_valid_ff && (rd_tag_ff == scan_last);
   assign cd_dec    = (countdown_ff == 16'd0) ? 16'd0 : countdown_ff - 16'd1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign emit_last = ({1'b0, emit_cnt_ff} == (digit_cnt - 4'd1));
   assign byte_fits = (wr_idx_ff < PW'(sdm_pkg::LINE_LENGTH));
   assign rd_char   = mem_hit_ff ? mem_q_ff : sdm_pkg::CHAR_NUL;

   assign rd_oob = (rd_addr > PW'(sdm_pkg::LINE_LENGTH));
   assign rd_sel = rd_oob ? '0 : rd_addr[sdm_pkg::STORE_AW-1:0];

   // Decision made once the window has been scanned.
   assign first_zero = (first_ff == sdm_pkg::CHAR_NUL);
   assign base_delay = first_zero ? end_delay_ff : char_delay_ff;
   assign quarter    = base_delay >> 2;
   assign blink_now  = !blanking_ff && !first_zero && (rd_idx_ff != '0) && blink_ok_ff;
   assign stop_now   = first_zero &&
                       ((end_delay_ff == 16'd0) || (text0_ff == sdm_pkg::CHAR_NUL));
   assign delay_new  = (blink_now != blanking_ff) ?
                       (blink_now ? quarter : base_delay - quarter) : base_delay;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      char_delay_in = char_delay_ff;
      end_delay_in  = end_delay_ff;
      digits_in     = digits_ff;
      if (csr_we) begin
         case (csr_index)
            sdm_pkg::CSR_CHAR_DELAY:    char_delay_in = csr_wdata;
            sdm_pkg::CSR_END_DELAY:     end_delay_in  = csr_wdata;
            sdm_pkg::CSR_DIGITS_IN_USE: digits_in     = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdm_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               if ((cmd_data.op == sdm_pkg::OP_BYTE) && byte_fits) begin
                  state_in = sdm_pkg::ST_TERM;
               end else if ((cmd_data.op == sdm_pkg::OP_TICK) && running_ff &&
                            (cd_dec == 16'd0)) begin
                  state_in = sdm_pkg::ST_SCAN;
               end
            end
         end
         sdm_pkg::ST_TERM:   state_in = sdm_pkg::ST_IDLE;
         sdm_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = sdm_pkg::ST_DECIDE;
            end
         end
         sdm_pkg::ST_DECIDE: state_in = sdm_pkg::ST_EMIT;
         sdm_pkg::ST_EMIT: begin
            if (rsp_free && emit_last) begin
               state_in = sdm_pkg::ST_IDLE;
            end
         end
         default: state_in = sdm_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls and register next values.
   always_comb begin
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = wr_idx_ff;
      mem_wdata    = sdm_pkg::CHAR_NUL;
      rd_en        = 1'b0;
      rd_addr      = scan_addr;
      win_we       = 1'b0;
      win_idx      = DW'(rd_tag_ff - SW'(2));
      win_data     = sdm_pkg::CHAR_SPACE;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      running_in   = running_ff;
      blanking_in  = blanking_ff;
      countdown_in = countdown_ff;
      issue_cnt_in = issue_cnt_ff;
      text0_in     = text0_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      blink_ok_in  = blink_ok_ff;
      zero_seen_in = zero_seen_ff;
      blink_in     = blink_ff;
      emit_cnt_in  = emit_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         sdm_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd_data.op)
                  sdm_pkg::OP_BYTE: begin
                     // A full line drops the byte; a byte that fits gets its terminator next cycle.
                     if (byte_fits) begin
                        mem_we    = 1'b1;
                        mem_wdata = cmd_data.char_val;
                     end
                  end
                  sdm_pkg::OP_NEWLINE: begin
                     mem_we    = 1'b1;
                     wr_idx_in = '0;
                     if (!running_ff) begin
                        running_in   = 1'b1;
                        blanking_in  = 1'b0;
                        rd_idx_in    = '0;
                        countdown_in = char_delay_ff;
                     end
                  end
                  sdm_pkg::OP_STOP: begin
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     wr_idx_in = '0;
                     rd_idx_in = '0;
                  end
                  sdm_pkg::OP_TICK: begin
                     if (running_ff) begin
                        countdown_in = cd_dec;
                        issue_cnt_in = '0;
                        blink_ok_in  = 1'b1;
                        zero_seen_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         sdm_pkg::ST_TERM: begin
            mem_we    = 1'b1;
            mem_waddr = wr_idx_ff + PW'(1);
            wr_idx_in = wr_idx_ff + PW'(1);
            rd_idx_in = '0;
         end
         sdm_pkg::ST_SCAN: begin
            // Reads go out as store[0], the character before the window, then the window.
            if (issue_cnt_ff <= scan_last) begin
               rd_en        = 1'b1;
               issue_cnt_in = issue_cnt_ff + SW'(1);
            end
            if (rd_valid_ff) begin
               if (rd_tag_ff == SW'(0)) begin
                  text0_in = rd_char;
               end else if (rd_tag_ff == SW'(1)) begin
                  prev_in = rd_char;
               end else begin
                  win_we       = 1'b1;
                  win_data     = (zero_seen_ff || (rd_char == sdm_pkg::CHAR_NUL)) ?
                                 sdm_pkg::CHAR_SPACE : rd_char;
                  zero_seen_in = zero_seen_ff || (rd_char == sdm_pkg::CHAR_NUL);
                  blink_ok_in  = blink_ok_ff && (rd_char != sdm_pkg::CHAR_NUL) &&
                                 (rd_char == prev_ff);
                  prev_in      = rd_char;
                  if (rd_tag_ff == SW'(2)) begin
                     first_in = rd_char;
                  end
               end
            end
         end
         sdm_pkg::ST_DECIDE: begin
            blink_in    = blink_now;
            blanking_in = blink_now;
            running_in  = running_ff && !stop_now;
            emit_cnt_in = '0;
            if (first_zero) begin
               rd_idx_in = '0;
            end else if (!blink_now) begin
               rd_idx_in = rd_idx_ff + PW'(1);
            end
            if (running_ff && !stop_now) begin
               countdown_in = delay_new;
            end
         end
         sdm_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.digit_index   = emit_cnt_ff;
               rsp_data_in.char_out      = blink_ff ? sdm_pkg::CHAR_SPACE :
                                           window_ff[emit_cnt_ff];
               rsp_data_in.last_digit    = emit_last;
               rsp_data_in.still_running = running_ff;
               emit_cnt_in               = emit_cnt_ff + DW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_delay_ff <= sdm_pkg::CHAR_DELAY_RST;
         end_delay_ff  <= sdm_pkg::END_DELAY_RST;
         digits_ff     <= sdm_pkg::DIGITS_RST;
         state_ff      <= sdm_pkg::ST_IDLE;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         running_ff    <= 1'b0;
         blanking_ff   <= 1'b0;
         countdown_ff  <= '0;
         issue_cnt_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         emit_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         vld_ff        <= '0;
      end else begin
         char_delay_ff <= char_delay_in;
         end_delay_ff  <= end_delay_in;
         digits_ff     <= digits_in;
         state_ff      <= state_in;
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         running_ff    <= running_in;
         blanking_ff   <= blanking_in;
         countdown_ff  <= countdown_in;
         issue_cnt_ff  <= issue_cnt_in;
         rd_valid_ff   <= rd_en;
         emit_cnt_ff   <= emit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (mem_we) begin
            vld_ff[mem_waddr[sdm_pkg::STORE_AW-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_tag_ff    <= issue_cnt_ff;
      text0_ff     <= text0_in;
      prev_ff      <= prev_in;
      first_ff     <= first_in;
      blink_ok_ff  <= blink_ok_in;
      zero_seen_ff <= zero_seen_in;
      blink_ff     <= blink_in;
      rsp_data_ff  <= rsp_data_in;
      if (win_we) begin
         window_ff[win_idx] <= win_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr[sdm_pkg::STORE_AW-1:0]] <= mem_wdata;
      end
      if (rd_en) begin
         mem_q_ff   <= store_mem[rd_sel];
         mem_hit_ff <= vld_ff[rd_sel] && !rd_oob;
      end
   end

`include "segment_display_marquee_macros.svh"

   `SDM_ASSERT_IMP(a_pop_idle, cmd_pop, state_ff == sdm_pkg::ST_IDLE, "command taken while busy")
   `SDM_ASSERT_IMP(a_read_in_scan, rd_valid_ff, state_ff == sdm_pkg::ST_SCAN, "read data outside scan")
   `SDM_ASSERT_IMP(a_pos_range, 1'b1, (rd_idx_ff <= PW'(sdm_pkg::LINE_LENGTH)) && (wr_idx_ff <= PW'(sdm_pkg::LINE_LENGTH)), "line position out of range")
   `SDM_ASSERT_NXT(a_last_word, (state_ff == sdm_pkg::ST_EMIT) && rsp_free && emit_last, rsp_valid_ff && rsp_data_ff.last_digit, "final digit word not flagged")

endmodule

// ----- dv/segment_display_marquee_test.sv -----
// Self-checking testbench for the segment display marquee: queued words, line predictor, digit checks.
module segment_display_marquee_test;

   localparam int         LIMIT_CYCLES  = 2_000_000;
   localparam int         SETTLE_CYCLES = 40;
   localparam int         RANDOM_WORDS  = 400;
   localparam logic [1:0] FUNC_UNUSED   = 2'd3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sdm_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sdm_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [15:0]      csr_wdata = '0;

   segment_display_marquee u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stimulus and expected digit words.
   sdm_pkg::req_type pending_words[$];
   sdm_pkg::rsp_type expected_digits[$];
   int      words_in_flight = 0;
   int      words_queued = 0;
   int      fail_count = 0;
   int      cycle_count = 0;
   bit      idling_on = 1'b1;

   // Mirror of the marquee state and its settings.
   logic [7:0]  line_mem [0:sdm_pkg::LINE_LENGTH];
   int          rd_pos = 0;
   int          wr_pos = 0;
   bit          scrolling = 1'b0;
   bit          blanked = 1'b0;
   logic [15:0] ticks_left = '0;
   logic [15:0] step_delay = sdm_pkg::CHAR_DELAY_RST;
   logic [15:0] pause_delay = sdm_pkg::END_DELAY_RST;
   logic [3:0]  digit_count = sdm_pkg::DIGITS_RST;

   initial begin
      for (int i = 0; i <= sdm_pkg::LINE_LENGTH; i++) line_mem[i] = sdm_pkg::CHAR_NUL;
   end

   function automatic logic [7:0] line_at(int p);
      return (p > sdm_pkg::LINE_LENGTH) ? sdm_pkg::CHAR_NUL : line_mem[p];
   endfunction

   // One display update: builds the frame and queues one word per digit.
   task automatic show_frame();
      int               n;
      int               pos;
      logic [7:0]       first;
      logic [7:0]       prev;
      logic [7:0]       ch;
      logic [15:0]      delay;
      logic [15:0]      quarter;
      bit               blink;
      sdm_pkg::rsp_type frame [sdm_pkg::MAX_DIGITS];
      n = digit_count;
      if (n == 0) n = 1;
      if (n > sdm_pkg::MAX_DIGITS) n = sdm_pkg::MAX_DIGITS;
      first = line_at(rd_pos);
      delay = (first == sdm_pkg::CHAR_NUL) ? pause_delay : step_delay;
      quarter = delay >> 2;
      blink = 1'b0;
      // A blank frame marks a step that would otherwise show the same characters.
      if (!blanked && first != sdm_pkg::CHAR_NUL && rd_pos > 0) begin
         prev = line_at(rd_pos - 1);
         blink = 1'b1;
         for (int l = 0; l < n && blink; l++) begin
            ch = line_at(rd_pos + l);
            if (ch == sdm_pkg::CHAR_NUL || ch != prev) blink = 1'b0;
            prev = ch;
         end
      end
      if (blink != blanked) begin
         blanked = blink;
         delay = blink ? quarter : delay - quarter;
      end
      pos = rd_pos;
      for (int l = 0; l < n; l++) begin
         ch = blink ? sdm_pkg::CHAR_NUL : line_at(pos);
         if (ch != sdm_pkg::CHAR_NUL) pos++;
         else ch = sdm_pkg::CHAR_SPACE;
         frame[l].digit_index = 3'(l);
         frame[l].char_out = ch;
         frame[l].last_digit = (l == n - 1);
      end
      if (first == sdm_pkg::CHAR_NUL) begin
         rd_pos = 0;
         if (pause_delay == 0 || line_mem[0] == sdm_pkg::CHAR_NUL) scrolling = 1'b0;
         else blanked = 1'b0;
      end else if (!blink) begin
         rd_pos++;
      end
      if (scrolling) ticks_left = delay;
      for (int l = 0; l < n; l++) begin
         frame[l].still_running = scrolling;
         expected_digits.push_back(frame[l]);
      end
   endtask

   task automatic predict_word(sdm_pkg::req_type w);
      case (w.func)
         sdm_pkg::FUNC_BYTE: begin
            if (w.char_in == sdm_pkg::CHAR_NL) begin
               line_mem[wr_pos] = sdm_pkg::CHAR_NUL;
               wr_pos = 0;
               if (!scrolling) begin
                  scrolling = 1'b1;
                  blanked = 1'b0;
                  rd_pos = 0;
                  ticks_left = step_delay;
               end
            end else if (w.char_in != sdm_pkg::CHAR_CR && wr_pos < sdm_pkg::LINE_LENGTH) begin
               line_mem[wr_pos] = w.char_in;
               line_mem[wr_pos + 1] = sdm_pkg::CHAR_NUL;
               wr_pos++;
               rd_pos = 0;
            end
         end
         sdm_pkg::FUNC_STOP: begin
            rd_pos = 0;
            wr_pos = 0;
            line_mem[0] = sdm_pkg::CHAR_NUL;
         end
         sdm_pkg::FUNC_TICK: begin
            if (scrolling) begin
               if (ticks_left > 0) ticks_left--;
               if (ticks_left == 0) show_frame();
            end
         end
         default: ;
      endcase
   endtask

   task automatic queue_word(logic [1:0] f, logic [7:0] c);
      sdm_pkg::req_type w;
      w.func = f;
      w.char_in = c;
      pending_words.push_back(w);
      words_in_flight++;
      words_queued++;
   endtask

   task automatic queue_tick();
      queue_word(sdm_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         sdm_pkg::CSR_CHAR_DELAY:    step_delay = value;
         sdm_pkg::CSR_END_DELAY:     pause_delay = value;
         sdm_pkg::CSR_DIGITS_IN_USE: digit_count = value[3:0];
         default: ;
      endcase
   endtask

   task automatic set_display(logic [15:0] cd, logic [15:0] ed, logic [3:0] dg);
      write_reg(sdm_pkg::CSR_CHAR_DELAY, cd);
      write_reg(sdm_pkg::CSR_END_DELAY, ed);
      write_reg(sdm_pkg::CSR_DIGITS_IN_USE, {12'd0, dg});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (words_in_flight != 0 || expected_digits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: presents queued words, with random idle bursts between them.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_word(req_data);
            words_in_flight--;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 15) == 0) begin
               send_gap = $urandom_range(0, 18);
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each digit word against the oldest expectation.
   int               stall_left = 0;
   sdm_pkg::rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_digits.size() == 0) begin
               $error("digit word with nothing expected: %h", rsp_data);
               fail_count++;
            end else begin
               want = expected_digits.pop_front();
               if (rsp_data.digit_index !== want.digit_index) begin
                  $error("digit_index: expected %0d, got %0d",
                         want.digit_index, rsp_data.digit_index);
                  fail_count++;
               end
               if (rsp_data.char_out !== want.char_out) begin
                  $error("char_out: expected %h, got %h", want.char_out, rsp_data.char_out);
                  fail_count++;
               end
               if (rsp_data.last_digit !== want.last_digit) begin
                  $error("last_digit: expected %0d, got %0d",
                         want.last_digit, rsp_data.last_digit);
                  fail_count++;
               end
               if (rsp_data.still_running !== want.still_running) begin
                  $error("still_running: expected %0d, got %0d",
                         want.still_running, rsp_data.still_running);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int          directed_words;
      int          phase_no;
      int          phase_words;
      int          len;
      int          nticks;
      int          pick;
      logic [7:0]  c;
      logic [15:0] cd_table [4];
      logic [15:0] ed_table [4];
      logic [3:0]  dg_table [4];
      cd_table = '{16'd0, 16'd1, 16'd3, 16'd2};
      ed_table = '{16'd0, 16'd3, 16'd0, 16'd5};
      dg_table = '{4'd0, 4'd15, 4'd1, 4'd8};
      c = "a";

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: ignored words, a repeated run that blanks, a high byte,
      // then a line that starts with a zero byte and so ends at once.
      set_display(16'd2, 16'd0, 4'd2);
      queue_tick();
      queue_word(FUNC_UNUSED, 8'hFF);
      queue_word(sdm_pkg::FUNC_BYTE, "A");
      queue_word(sdm_pkg::FUNC_BYTE, "A");
      queue_word(sdm_pkg::FUNC_BYTE, sdm_pkg::CHAR_CR);
      queue_word(sdm_pkg::FUNC_BYTE, "A");
      queue_word(sdm_pkg::FUNC_BYTE, 8'hFF);
      queue_word(sdm_pkg::FUNC_BYTE, sdm_pkg::CHAR_NL);
      repeat (12) queue_tick();
      queue_word(sdm_pkg::FUNC_STOP, 8'h55);
      queue_word(sdm_pkg::FUNC_BYTE, sdm_pkg::CHAR_NUL);
      queue_word(sdm_pkg::FUNC_BYTE, "Z");
      queue_word(sdm_pkg::FUNC_BYTE, sdm_pkg::CHAR_NL);
      repeat (4) queue_tick();
      directed_words = words_queued;
      wait_idle();

      phase_no = 0;
      while (words_queued - directed_words < RANDOM_WORDS) begin
         if (phase_no < 4) begin
            set_display(cd_table[phase_no], ed_table[phase_no], dg_table[phase_no]);
         end else begin
            set_display(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 12))
                                                    : 16'($urandom_range(0, 3)),
                        ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 8)),
                        4'($urandom_range(0, 15)));
         end
         // The last stretch of the run goes without idling.
         if (words_queued - directed_words >= RANDOM_WORDS - 80) idling_on = 1'b0;
         phase_words = 0;
         while (phase_words < 50) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 10);
            for (int k = 0; k < len; k++) begin
               pick = $urandom_range(0, 19);
               if (pick < 2) c = 8'($urandom_range(0, 255));
               else if (pick >= 10) c = 8'($urandom_range(8'h21, 8'h7E));
               queue_word(sdm_pkg::FUNC_BYTE, c);
               if ($urandom_range(0, 19) == 0) queue_word(sdm_pkg::FUNC_BYTE, sdm_pkg::CHAR_CR);
            end
            // Now and then a line is left open, so later bytes extend it.
            if ($urandom_range(0, 15) != 0) queue_word(sdm_pkg::FUNC_BYTE, sdm_pkg::CHAR_NL);
            nticks = (len + 3) * (step_delay + 1) + pause_delay;
            if (nticks > 60) nticks = 60;
            for (int k = 0; k < nticks; k++) begin
               pick = $urandom_range(0, 39);
               if (pick == 0) queue_word(sdm_pkg::FUNC_STOP, 8'($urandom_range(0, 255)));
               else if (pick == 1) queue_word(FUNC_UNUSED, 8'($urandom_range(0, 255)));
               else queue_tick();
            end
            phase_words += len + nticks + 1;
         end
         wait_idle();
         phase_no++;
      end

      // Longest delays: only a few ticks, since a full delay would take too long.
      idling_on = 1'b0;
      set_display(16'hFFFF, 16'hFFFF, 4'd8);
      queue_word(sdm_pkg::FUNC_STOP, 8'h00);
      queue_word(sdm_pkg::FUNC_BYTE, "H");
      queue_word(sdm_pkg::FUNC_BYTE, "I");
      queue_word(sdm_pkg::FUNC_BYTE, sdm_pkg::CHAR_NL);
      repeat (6) queue_tick();
      wait_idle();

      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
